[sv/csghlf_pkg.sv]
package csghlf_pkg;

   localparam int HIT_TYPE_WIDTH  = 2;
   localparam int MODE_WIDTH      = 2;
   localparam int OBJ_COUNT_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef logic [HIT_TYPE_WIDTH-1:0]  hit_type_type;
   typedef logic [MODE_WIDTH-1:0]      mode_type;
   typedef logic [OBJ_COUNT_WIDTH-1:0] obj_count_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam hit_type_type HIT_ENTRY   = 2'd0;
   localparam hit_type_type HIT_LEAVE   = 2'd1;
   localparam hit_type_type HIT_SURFACE = 2'd2;
   localparam hit_type_type HIT_UNUSED  = 2'd3;

   localparam mode_type MODE_UNION      = 2'd0;
   localparam mode_type MODE_INTERSECT  = 2'd1;
   localparam mode_type MODE_DIFFERENCE = 2'd2;

   localparam csr_index_type CSR_MODE      = 1'd0;
   localparam csr_index_type CSR_OBJ_COUNT = 1'd1;

   localparam mode_type      MODE_RESET      = MODE_UNION;
   localparam obj_count_type OBJ_COUNT_RESET = 8'd2;

   // classification of one hit
   typedef struct packed {
      logic         keep;
      hit_type_type hit_type_out;
   } verdict_type;

endpackage

[sv/csghlf_classify.sv]
module csghlf_classify #(
   parameter int COUNT_WIDTH = 8
) (
   input  csghlf_pkg::mode_type      mode,
   input  csghlf_pkg::obj_count_type object_count,
   input  csghlf_pkg::hit_type_type  hit_type,
   input  logic                      from_primary,
   input  logic                      last_in,
   input  logic [COUNT_WIDTH-1:0]    count,
   input  logic                      inside_primary,
   output logic [COUNT_WIDTH-1:0]    count_next,
   output logic                      inside_primary_next,
   output csghlf_pkg::verdict_type   verdict
);
   import csghlf_pkg::*;

   localparam int CmpWidth = ((COUNT_WIDTH > OBJ_COUNT_WIDTH) ? COUNT_WIDTH
                                                               : OBJ_COUNT_WIDTH) + 1;

   hit_type_type           type_n;
   logic [COUNT_WIDTH-1:0] count_up;
   logic [COUNT_WIDTH-1:0] count_dn;
   logic [CmpWidth-1:0]    count_ext;
   logic [CmpWidth-1:0]    up_ext;
   logic [CmpWidth-1:0]    oc_ext;
   logic [COUNT_WIDTH-1:0] count_upd;
   logic                   prim_upd;

   always_comb begin
      type_n    = (hit_type == HIT_UNUSED) ? HIT_SURFACE : hit_type;
      // saturating at both ends
      count_up  = (&count) ? count : count + COUNT_WIDTH'(1);
      count_dn  = (count == '0) ? count : count - COUNT_WIDTH'(1);
      count_ext = CmpWidth'(count);
      up_ext    = CmpWidth'(count_up);
      oc_ext    = CmpWidth'(object_count);

      count_upd            = count;
      prim_upd             = inside_primary;
      verdict.keep         = 1'b0;
      verdict.hit_type_out = type_n;

      case (mode)
         MODE_INTERSECT: begin
            case (type_n)
               HIT_ENTRY: begin
                  count_upd    = count_up;
                  verdict.keep = (up_ext >= oc_ext);
               end
               HIT_LEAVE: begin
                  count_upd    = count_dn;
                  verdict.keep = (count_ext >= oc_ext);
               end
               default: begin
                  // count >= object_count - 1, kept free of the negative case
                  verdict.keep = (count_ext + CmpWidth'(1) >= oc_ext);
               end
            endcase
         end
         MODE_DIFFERENCE: begin
            if (from_primary) begin
               prim_upd     = (type_n == HIT_ENTRY);
               verdict.keep = (count == '0);
            end else begin
               case (type_n)
                  HIT_ENTRY: begin
                     count_upd            = count_up;
                     verdict.hit_type_out = HIT_LEAVE;
                     verdict.keep = inside_primary && (count_up == COUNT_WIDTH'(1));
                  end
                  HIT_LEAVE: begin
                     count_upd            = count_dn;
                     verdict.hit_type_out = HIT_ENTRY;
                     verdict.keep         = inside_primary && (count_dn == '0);
                  end
                  default: begin
                     verdict.keep = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            case (type_n)
               HIT_ENTRY: begin
                  count_upd    = count_up;
                  verdict.keep = (count_up <= COUNT_WIDTH'(1));
               end
               HIT_LEAVE: begin
                  count_upd    = count_dn;
                  verdict.keep = (count_dn == '0);
               end
               default: begin
                  verdict.keep = (count == '0);
               end
            endcase
         end
      endcase

      count_next          = last_in ? '0 : count_upd;
      inside_primary_next = last_in ? 1'b0 : prim_upd;
   end

endmodule

[sv/csg_hit_list_filter.sv]
// an accepted hit is registered and shows on rsp_* from the result register
// throughput: one hit per cycle while rsp_ready is high, via one counter path
// req_ready stays high while the result register is empty or being taken
// reset (synchronous, active high) clears the inside counter, the primary flag
// and the result valid, and sets mode to union and object_count to 2
module csg_hit_list_filter #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csghlf_pkg::hit_type_type  req_hit_type,
   input  logic                      req_from_primary,
   input  logic                      req_last_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_keep,
   output csghlf_pkg::hit_type_type  rsp_hit_type_out,
   output logic                      rsp_last_out,
   input  logic                      csr_write_enable,
   input  csghlf_pkg::csr_index_type csr_index,
   input  csghlf_pkg::csr_data_type  csr_write_data
);
   import csghlf_pkg::*;

   mode_type               mode_ff;
   obj_count_type          obj_count_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   prim_ff;
   logic                   prim_in;
   logic                   valid_ff;
   verdict_type            verdict_ff;
   verdict_type            verdict_in;
   logic                   last_ff;
   logic                   accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   csghlf_classify #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_classify (
      .mode                (mode_ff),
      .object_count        (obj_count_ff),
      .hit_type            (req_hit_type),
      .from_primary        (req_from_primary),
      .last_in             (req_last_in),
      .count               (count_ff),
      .inside_primary      (prim_ff),
      .count_next          (count_in),
      .inside_primary_next (prim_in),
      .verdict             (verdict_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         obj_count_ff <= OBJ_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_write_data[MODE_WIDTH-1:0];
            CSR_OBJ_COUNT: obj_count_ff <= csr_write_data[OBJ_COUNT_WIDTH-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prim_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         prim_ff  <= prim_in;
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         verdict_ff <= verdict_in;
         last_ff    <= req_last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_keep         = verdict_ff.keep;
   assign rsp_hit_type_out = verdict_ff.hit_type_out;
   assign rsp_last_out     = last_ff;

endmodule
